// File: rtl/core/cov_acc_pkg.sv
// Shared types and constants for the covariance accumulator.
// Holds the mode codes, controller states and the command/status structs.
// No dependencies.
`default_nettype none

package cov_acc_pkg;

  localparam int unsigned DEF_SAMPLE_BITS = 16;
  localparam int unsigned DEF_COUNT_BITS  = 24;
  localparam int unsigned MODE_BITS       = 2;
  localparam int unsigned COV_BITS        = 32;
  localparam int unsigned MUL_DIGIT       = 8;

  localparam logic [COV_BITS-1:0] COV_MAX = 32'h7FFF_FFFF;
  localparam logic [COV_BITS-1:0] COV_MIN = 32'h8000_0000;

  // Default sequencing figures, derived the same way the top level derives them
  localparam int unsigned DEF_SUM_BITS  = DEF_SAMPLE_BITS + DEF_COUNT_BITS;
  localparam int unsigned DEF_MUL_STEPS = (DEF_SUM_BITS + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int unsigned DEF_PROD_W    = DEF_SUM_BITS + DEF_MUL_STEPS * MUL_DIGIT;
  localparam int unsigned DEF_DIV_STEPS = (DEF_PROD_W + (DEF_PROD_W % 2)) / 2;
  localparam int unsigned DEF_STEP_BITS = $clog2(DEF_DIV_STEPS);

  typedef enum logic [MODE_BITS-1:0] {
    MODE_ADD   = 2'd0,
    MODE_MERGE = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_LOAD_P,
    ST_DIV_P,
    ST_DIFF,
    ST_LOAD_D,
    ST_DIV_D,
    ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic apply;
    logic load_mul;
    logic mul_step;
    logic load_div_p;
    logic div_step;
    logic form_diff;
    logic load_div_d;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/core/cov_acc_ctrl.sv
// Controller for the covariance accumulator: sequences apply, multiply,
// two divider passes and the result load. Depends on cov_acc_pkg.
`default_nettype none

module cov_acc_ctrl import cov_acc_pkg::*; #(
  parameter int unsigned MUL_STEPS = DEF_MUL_STEPS,
  parameter int unsigned DIV_STEPS = DEF_DIV_STEPS,
  parameter int unsigned STEP_BITS = DEF_STEP_BITS
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  wire logic  m_tready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  ctrl_state_t          state, state_next;
  logic [STEP_BITS-1:0] cnt, cnt_next;
  logic                 m_tvalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.apply  = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load_mul = 1'b1;
        cnt_next     = '0;
        state_next   = stat.count_zero ? ST_FIN : ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == STEP_BITS'(MUL_STEPS - 1)) begin
          state_next = ST_LOAD_P;
        end
      end
      ST_LOAD_P: begin
        cmd.load_div_p = 1'b1;
        cnt_next       = '0;
        state_next     = ST_DIV_P;
      end
      ST_DIV_P: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == STEP_BITS'(DIV_STEPS - 1)) begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.form_diff = 1'b1;
        state_next    = ST_LOAD_D;
      end
      ST_LOAD_D: begin
        cmd.load_div_d = 1'b1;
        cnt_next       = '0;
        state_next     = ST_DIV_D;
      end
      ST_DIV_D: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == STEP_BITS'(DIV_STEPS - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!m_tvalid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign m_tvalid_next = (m_tvalid && !m_tready) || cmd.load_out;

endmodule

`default_nettype wire

// File: rtl/core/cov_acc_dp.sv
// Datapath for the covariance accumulator: running sums with range check,
// digit-serial multiplier, radix-4 divider and output register. Uses cov_acc_pkg.
`default_nettype none

module cov_acc_dp import cov_acc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned COUNT_BITS  = DEF_COUNT_BITS,
  parameter int unsigned SUM_BITS    = DEF_SUM_BITS,
  parameter int unsigned PROD_BITS   = DEF_SAMPLE_BITS * 2 + DEF_COUNT_BITS,
  parameter int unsigned MUL_BITS    = DEF_MUL_STEPS * MUL_DIGIT,
  parameter int unsigned DIV_BITS    = DEF_DIV_STEPS * 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cmd_t                          cmd,
  output stat_t                              stat,
  input  wire logic        [MODE_BITS-1:0]   mode,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_f,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_g,
  input  wire logic        [COUNT_BITS-1:0]  seg_count,
  input  wire logic signed [SUM_BITS-1:0]    seg_sum_f,
  input  wire logic signed [SUM_BITS-1:0]    seg_sum_g,
  input  wire logic signed [PROD_BITS-1:0]   seg_sum_product,
  output logic             [COV_BITS-1:0]    cov_out,
  output logic             [COUNT_BITS-1:0]  count_out,
  output logic                               ovf_out
);

  localparam int unsigned PW = SUM_BITS + MUL_BITS;
  localparam int unsigned MW = SUM_BITS + MUL_DIGIT;
  localparam int unsigned RW = (DIV_BITS > COV_BITS + 1) ? DIV_BITS : COV_BITS + 1;

  // architectural state
  logic        [COUNT_BITS-1:0] sample_count;
  logic signed [SUM_BITS-1:0]   sum_f, sum_g;
  logic signed [PROD_BITS-1:0]  sum_product;
  logic                         overflow_seen;

  // update terms
  logic signed [2*SAMPLE_BITS-1:0] fg;
  logic        [COUNT_BITS-1:0]    dn;
  logic signed [SUM_BITS-1:0]      df, dg;
  logic signed [PROD_BITS-1:0]     dp;
  logic        [COUNT_BITS:0]      nn;
  logic signed [SUM_BITS:0]        nf, ng;
  logic signed [PROD_BITS:0]       np;
  logic                            fits_all;

  // multiply and divide working registers
  logic [SUM_BITS-1:0]   mul_a;
  logic [PW-1:0]         prod;
  logic [MW-1:0]         mt;
  logic                  neg_p;
  logic [DIV_BITS-1:0]   quo;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS+1:0] n1, n2, n3, r4, rsub;
  logic [1:0]            digit;
  logic signed [DIV_BITS:0] diff;
  logic [DIV_BITS:0]     spx, qext, dneg;
  logic [DIV_BITS-1:0]   dmag;
  logic                  neg_d;
  logic [SUM_BITS-1:0]   fmag, gmag;
  logic signed [SUM_BITS-1:0] fneg, gneg;
  logic [RW-1:0]         rx;
  logic [COV_BITS-1:0]   cov_res;

  assign fg = sample_f * sample_g;

  always_comb begin
    dn = '0;
    df = '0;
    dg = '0;
    dp = '0;
    unique case (mode_t'(mode))
      MODE_ADD: begin
        dn = COUNT_BITS'(1);
        df = SUM_BITS'(sample_f);
        dg = SUM_BITS'(sample_g);
        dp = PROD_BITS'(fg);
      end
      MODE_MERGE: begin
        dn = seg_count;
        df = seg_sum_f;
        dg = seg_sum_g;
        dp = seg_sum_product;
      end
      default: begin
      end
    endcase
  end

  assign nn = {1'b0, sample_count} + {1'b0, dn};
  assign nf = (SUM_BITS+1)'(sum_f) + (SUM_BITS+1)'(df);
  assign ng = (SUM_BITS+1)'(sum_g) + (SUM_BITS+1)'(dg);
  assign np = (PROD_BITS+1)'(sum_product) + (PROD_BITS+1)'(dp);
  assign fits_all = !nn[COUNT_BITS] && (nf[SUM_BITS] == nf[SUM_BITS-1]) &&
                    (ng[SUM_BITS] == ng[SUM_BITS-1]) &&
                    (np[PROD_BITS] == np[PROD_BITS-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count  <= '0;
      sum_f         <= '0;
      sum_g         <= '0;
      sum_product   <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.apply) begin
      unique case (mode_t'(mode)) inside
        MODE_ADD, MODE_MERGE: begin
          if (fits_all) begin
            sample_count <= nn[COUNT_BITS-1:0];
            sum_f        <= nf[SUM_BITS-1:0];
            sum_g        <= ng[SUM_BITS-1:0];
            sum_product  <= np[PROD_BITS-1:0];
          end else begin
            overflow_seen <= 1'b1;
          end
        end
        MODE_CLEAR: begin
          sample_count  <= '0;
          sum_f         <= '0;
          sum_g         <= '0;
          sum_product   <= '0;
          overflow_seen <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.count_zero = (sample_count == '0);

  // magnitudes of the two sums
  assign fneg = -sum_f;
  assign gneg = -sum_g;
  assign fmag = sum_f[SUM_BITS-1] ? fneg : sum_f;
  assign gmag = sum_g[SUM_BITS-1] ? gneg : sum_g;

  // one multiplier digit per step, partial product shifts right
  assign mt = MW'(prod[PW-1:MUL_BITS]) + MW'(mul_a) * MW'(prod[MUL_DIGIT-1:0]);

  // radix-4 restoring step against n, 2n and 3n
  assign n1 = (COUNT_BITS+2)'(sample_count);
  assign n2 = {1'b0, sample_count, 1'b0};
  assign r4 = {rem, quo[DIV_BITS-1 -: 2]};

  always_comb begin
    if (r4 >= n3) begin
      digit = 2'd3;
      rsub  = r4 - n3;
    end else if (r4 >= n2) begin
      digit = 2'd2;
      rsub  = r4 - n2;
    end else if (r4 >= n1) begin
      digit = 2'd1;
      rsub  = r4 - n1;
    end else begin
      digit = 2'd0;
      rsub  = r4;
    end
  end

  assign spx  = (DIV_BITS+1)'(sum_product);
  assign qext = {1'b0, quo};
  assign dneg = -diff;
  assign dmag = diff[DIV_BITS] ? dneg[DIV_BITS-1:0] : diff[DIV_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_mul) begin
      mul_a <= fmag;
      prod  <= PW'(gmag);
      neg_p <= sum_f[SUM_BITS-1] ^ sum_g[SUM_BITS-1];
    end else if (cmd.mul_step) begin
      prod <= {mt, prod[MUL_BITS-1:MUL_DIGIT]};
    end

    if (cmd.load_div_p) begin
      quo <= DIV_BITS'(prod);
      rem <= '0;
      n3  <= n2 + n1;
    end else if (cmd.load_div_d) begin
      quo   <= dmag;
      rem   <= '0;
      neg_d <= diff[DIV_BITS];
    end else if (cmd.div_step) begin
      quo <= {quo[DIV_BITS-3:0], digit};
      rem <= rsub[COUNT_BITS-1:0];
    end

    // subtract the signed product term, truncated toward zero
    if (cmd.form_diff) begin
      diff <= neg_p ? (spx + qext) : (spx - qext);
    end
  end

  // saturate the final quotient into the 32-bit result
  assign rx = RW'(quo);

  always_comb begin
    if (stat.count_zero) begin
      cov_res = '0;
    end else if (neg_d) begin
      cov_res = (rx > RW'(COV_MIN)) ? COV_MIN : -rx[COV_BITS-1:0];
    end else begin
      cov_res = (rx > RW'(COV_MAX)) ? COV_MAX : rx[COV_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cov_out   <= cov_res;
      count_out <= sample_count;
      ovf_out   <= overflow_seen;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/covariance_accumulator.sv
// Covariance accumulator: an accepted item runs load, multiply, a radix-4
// divider pass, the difference, a second divider pass (each a DIV_BITS dividend
// by the sample count) and the result load; s_tready rises with m_tvalid, and
// no item is taken while one is in work. An empty count skips to the result.
// A finished result waits in the output register while a new item is accepted.
// Synchronous reset clears all sums, the count and the overflow flag.
`default_nettype none

module covariance_accumulator import cov_acc_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned COUNT_BITS  = DEF_COUNT_BITS,
  localparam int unsigned SUM_BITS   = (SAMPLE_BITS + COUNT_BITS > 62) ? 62 :
                                       SAMPLE_BITS + COUNT_BITS,
  localparam int unsigned PROD_BITS  = (2 * SAMPLE_BITS + COUNT_BITS > 62) ? 62 :
                                       2 * SAMPLE_BITS + COUNT_BITS,
  localparam int unsigned IN_BITS    = 2 * SAMPLE_BITS + COUNT_BITS + 2 * SUM_BITS +
                                       PROD_BITS,
  localparam int unsigned IN_W       = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS   = COV_BITS + COUNT_BITS + 1,
  localparam int unsigned OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // sample_f, sample_g, seg_count, seg_sum_f, seg_sum_g, seg_sum_product, zero pad
  input  wire logic [IN_W-1:0]      s_tdata,
  // mode
  input  wire logic [MODE_BITS-1:0] s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // covariance, total_count, overflow, zero pad
  output logic [OUT_W-1:0]          m_tdata
);

  localparam int unsigned MUL_STEPS = (SUM_BITS + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int unsigned MUL_BITS  = MUL_STEPS * MUL_DIGIT;
  localparam int unsigned PW        = SUM_BITS + MUL_BITS;
  localparam int unsigned DIV_BITS  = PW + (PW % 2);
  localparam int unsigned DIV_STEPS = DIV_BITS / 2;
  localparam int unsigned STEP_BITS = $clog2(DIV_STEPS);

  localparam int unsigned OFS_G  = SAMPLE_BITS;
  localparam int unsigned OFS_SC = 2 * SAMPLE_BITS;
  localparam int unsigned OFS_SF = OFS_SC + COUNT_BITS;
  localparam int unsigned OFS_SG = OFS_SF + SUM_BITS;
  localparam int unsigned OFS_SP = OFS_SG + SUM_BITS;

  cmd_t  cmd;
  stat_t stat;

  logic signed [SAMPLE_BITS-1:0] sample_f, sample_g;
  logic        [COUNT_BITS-1:0]  seg_count;
  logic signed [SUM_BITS-1:0]    seg_sum_f, seg_sum_g;
  logic signed [PROD_BITS-1:0]   seg_sum_product;
  logic        [COV_BITS-1:0]    cov_out;
  logic        [COUNT_BITS-1:0]  count_out;
  logic                          ovf_out;

  assign sample_f        = $signed(s_tdata[0 +: SAMPLE_BITS]);
  assign sample_g        = $signed(s_tdata[OFS_G +: SAMPLE_BITS]);
  assign seg_count       = s_tdata[OFS_SC +: COUNT_BITS];
  assign seg_sum_f       = $signed(s_tdata[OFS_SF +: SUM_BITS]);
  assign seg_sum_g       = $signed(s_tdata[OFS_SG +: SUM_BITS]);
  assign seg_sum_product = $signed(s_tdata[OFS_SP +: PROD_BITS]);

  cov_acc_ctrl #(
    .MUL_STEPS (MUL_STEPS),
    .DIV_STEPS (DIV_STEPS),
    .STEP_BITS (STEP_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cov_acc_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .SUM_BITS    (SUM_BITS),
    .PROD_BITS   (PROD_BITS),
    .MUL_BITS    (MUL_BITS),
    .DIV_BITS    (DIV_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .mode            (s_tuser),
    .sample_f        (sample_f),
    .sample_g        (sample_g),
    .seg_count       (seg_count),
    .seg_sum_f       (seg_sum_f),
    .seg_sum_g       (seg_sum_g),
    .seg_sum_product (seg_sum_product),
    .cov_out         (cov_out),
    .count_out       (count_out),
    .ovf_out         (ovf_out)
  );

  assign m_tdata = OUT_W'({ovf_out, count_out, cov_out});

`ifndef SYNTHESIS
  // one item at a time: no second item right after an accepted one
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while previous item still in work");

  // a fresh result only comes out of the busy sequence
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared while controller was idle");

  // an empty accumulator reports zero covariance
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (count_out == '0) |-> (cov_out == '0))
    else $error("nonzero covariance with zero count");
`endif

endmodule

`default_nettype wire

// File: tb/sv/covariance_checker.sv
// Scoreboard for the covariance accumulator: watches both stream channels,
// predicts each result from its own running sums and compares field by field.
// Depends on cov_acc_pkg for the mode codes and the covariance limits.
`default_nettype none

module covariance_checker import cov_acc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  input  wire logic                 s_tready,
  // sample_f, sample_g, seg_count, seg_sum_f, seg_sum_g, seg_sum_product
  input  wire logic [191:0]         s_tdata,
  // mode
  input  wire logic [MODE_BITS-1:0] s_tuser,
  input  wire logic                 m_tvalid,
  input  wire logic                 m_tready,
  // covariance, total_count, overflow, zero pad
  input  wire logic [63:0]          m_tdata,
  output int                        errors,
  output int                        outstanding
);

  localparam int SMP_W = DEF_SAMPLE_BITS;
  localparam int CNT_W = DEF_COUNT_BITS;
  localparam int SUM_W = SMP_W + CNT_W;
  localparam int PRD_W = 2 * SMP_W + CNT_W;

  localparam int F_LO   = 0;
  localparam int G_LO   = F_LO + SMP_W;
  localparam int CNT_LO = G_LO + SMP_W;
  localparam int SF_LO  = CNT_LO + CNT_W;
  localparam int SG_LO  = SF_LO + SUM_W;
  localparam int SP_LO  = SG_LO + SUM_W;

  localparam logic [127:0]        CNT_MAX = (128'd1 << CNT_W) - 128'd1;
  localparam logic signed [127:0] SUM_HI  = (128'sd1 <<< (SUM_W - 1)) - 128'sd1;
  localparam logic signed [127:0] SUM_LO  = -(128'sd1 <<< (SUM_W - 1));
  localparam logic signed [127:0] PRD_HI  = (128'sd1 <<< (PRD_W - 1)) - 128'sd1;
  localparam logic signed [127:0] PRD_LO  = -(128'sd1 <<< (PRD_W - 1));

  typedef struct packed {
    logic [COV_BITS-1:0] cov;
    logic [CNT_W-1:0]    count;
    logic                ovf;
  } cov_result_t;

  logic [CNT_W-1:0]        acc_count;
  logic signed [SUM_W-1:0] acc_f;
  logic signed [SUM_W-1:0] acc_g;
  logic signed [PRD_W-1:0] acc_p;
  logic                    acc_ovf;
  cov_result_t             results_q[$];

  // (Sfg - Sf*Sg/n)/n with both divisions truncating toward zero, then saturate
  function automatic logic [COV_BITS-1:0] population_cov();
    logic signed [127:0] n, wf, wg, wp, q, r, hi, lo;
    if (acc_count == '0) return '0;
    n  = acc_count;
    wf = acc_f;
    wg = acc_g;
    wp = acc_p;
    hi = {96'd0, COV_MAX};
    lo = {{96{1'b1}}, COV_MIN};
    q  = (wf * wg) / n;
    r  = (wp - q) / n;
    if (r > hi) return COV_MAX;
    if (r < lo) return COV_MIN;
    return r[COV_BITS-1:0];
  endfunction

  task automatic fold_item(input logic [MODE_BITS-1:0] md, input logic [191:0] d);
    logic signed [127:0] df, dg, dp, nf, ng, np;
    logic [127:0]        dn, nn;
    logic                do_apply;
    do_apply = 1'b1;
    dn = '0;
    df = '0;
    dg = '0;
    dp = '0;
    case (md)
      MODE_ADD: begin
        df = $signed(d[F_LO +: SMP_W]);
        dg = $signed(d[G_LO +: SMP_W]);
        dp = df * dg;
        dn = 128'd1;
      end
      MODE_MERGE: begin
        dn = d[CNT_LO +: CNT_W];
        df = $signed(d[SF_LO +: SUM_W]);
        dg = $signed(d[SG_LO +: SUM_W]);
        dp = $signed(d[SP_LO +: PRD_W]);
      end
      MODE_CLEAR: begin
        acc_count = '0;
        acc_f     = '0;
        acc_g     = '0;
        acc_p     = '0;
        acc_ovf   = 1'b0;
        do_apply  = 1'b0;
      end
      default: do_apply = 1'b0;
    endcase
    if (do_apply) begin
      nn = dn + acc_count;
      nf = df + acc_f;
      ng = dg + acc_g;
      np = dp + acc_p;
      // refuse the whole update when anything leaves its range
      if (nn > CNT_MAX || nf > SUM_HI || nf < SUM_LO || ng > SUM_HI || ng < SUM_LO ||
          np > PRD_HI || np < PRD_LO) begin
        acc_ovf = 1'b1;
      end else begin
        acc_count = nn[CNT_W-1:0];
        acc_f     = nf[SUM_W-1:0];
        acc_g     = ng[SUM_W-1:0];
        acc_p     = np[PRD_W-1:0];
      end
    end
  endtask

  always @(posedge clk) begin
    cov_result_t want;
    if (rst) begin
      acc_count = '0;
      acc_f     = '0;
      acc_g     = '0;
      acc_p     = '0;
      acc_ovf   = 1'b0;
      results_q.delete();
      errors      = 0;
      outstanding = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (results_q.size() == 0) begin
          $error("result with no item pending: covariance %0d, total_count %0d, overflow %0b",
                 $signed(m_tdata[31:0]), m_tdata[55:32], m_tdata[56]);
          errors = errors + 1;
        end else begin
          want = results_q.pop_front();
          if (m_tdata[31:0] !== want.cov) begin
            $error("covariance: expected %0d, got %0d", $signed(want.cov),
                   $signed(m_tdata[31:0]));
            errors = errors + 1;
          end
          if (m_tdata[55:32] !== want.count) begin
            $error("total_count: expected %0d, got %0d", want.count, m_tdata[55:32]);
            errors = errors + 1;
          end
          if (m_tdata[56] !== want.ovf) begin
            $error("overflow: expected %0b, got %0b", want.ovf, m_tdata[56]);
            errors = errors + 1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        fold_item(s_tuser, s_tdata);
        want.cov   = population_cov();
        want.count = acc_count;
        want.ovf   = acc_ovf;
        results_q.push_back(want);
      end
      outstanding = results_q.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Top of the covariance accumulator testbench: clock, reset, directed and random
// items with random idling on both channels, watchdog and verdict.
// Depends on cov_acc_pkg, covariance_accumulator and covariance_checker.
`default_nettype none

module testbench;
  import cov_acc_pkg::*;

  localparam int IN_W           = 192;
  localparam int OUT_W          = 64;
  localparam int RANDOM_ITEMS   = 850;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int END_CYCLES     = 200;

  localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

  localparam logic [39:0] SUM_MAX = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] SUM_MIN = 40'h80_0000_0000;
  localparam logic [55:0] PRD_MAX = 56'h7F_FFFF_FFFF_FFFF;
  localparam logic [55:0] PRD_MIN = 56'h80_0000_0000_0000;
  localparam logic [23:0] CNT_TOP = 24'hFF_FFFF;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata;
  logic [MODE_BITS-1:0] s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OUT_W-1:0]     m_tdata;
  int                   errors;
  int                   outstanding;
  int                   tx_idle_pct;
  int                   rx_idle_pct;
  int                   quiet_cycles;

  covariance_accumulator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  covariance_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [IN_W-1:0] pack_item(input logic [15:0] f, input logic [15:0] g,
                                                 input logic [23:0] n, input logic [39:0] sf,
                                                 input logic [39:0] sg, input logic [55:0] sp);
    return {sp, sg, sf, n, g, f};
  endfunction

  function automatic logic [IN_W-1:0] noise_word();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // uniform bits, sign-extended from a width of w
  function automatic logic signed [63:0] rand_signed(input int w);
    logic signed [63:0] v;
    v = {$urandom, $urandom};
    return v >>> (64 - w);
  endfunction

  task automatic send(input logic [MODE_BITS-1:0] md, input logic [IN_W-1:0] word);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= md;
    s_tdata  <= word;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    @(negedge clk);
  endtask

  // receiver back-pressure
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [IN_W-1:0] word;
    logic [IN_W-1:0] seg_word;
    int              pick;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = MODE_ADD;
    tx_idle_pct  = 22;
    rx_idle_pct  = 54;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, every mode, refusals, saturation
    send(MODE_SPARE, noise_word());
    send(MODE_ADD, pack_item(16'h7FFF, 16'h7FFF, '0, '0, '0, '0));
    send(MODE_ADD, pack_item(16'h8000, 16'h8000, '0, '0, '0, '0));
    send(MODE_ADD, pack_item(16'h8000, 16'h7FFF, '0, '0, '0, '0));
    send(MODE_ADD, pack_item(16'h7FFF, 16'h8000, '0, '0, '0, '0));
    send(MODE_ADD, pack_item('0, '0, '1, '1, '1, '1));
    send(MODE_MERGE, pack_item('1, '1, '0, 40'd100, -40'sd50, 56'd7));
    send(MODE_CLEAR, noise_word());
    send(MODE_MERGE, pack_item('0, '0, 24'd1, '0, '0, PRD_MAX));
    send(MODE_CLEAR, '0);
    send(MODE_MERGE, pack_item('0, '0, 24'd1, '0, '0, PRD_MIN));
    send(MODE_CLEAR, '0);
    send(MODE_MERGE, pack_item('0, '0, CNT_TOP, SUM_MAX, SUM_MIN, '0));
    send(MODE_ADD, pack_item(16'd1, 16'd1, '0, '0, '0, '0));
    send(MODE_SPARE, '0);
    send(MODE_MERGE, pack_item('0, '0, '0, 40'd1, '0, '0));
    send(MODE_CLEAR, '0);
    send(MODE_MERGE, pack_item('0, '0, '0, '0, '0, PRD_MAX));
    send(MODE_MERGE, pack_item('0, '0, '0, '0, '0, 56'd1));
    send(MODE_CLEAR, '0);
    send(MODE_MERGE, pack_item('0, '0, 24'd3, -40'sd5, 40'd7, -56'sd19));
    send(MODE_MERGE, pack_item('0, '0, CNT_TOP, SUM_MIN, SUM_MIN, PRD_MIN));
    send(MODE_SPARE, noise_word());
    send(MODE_CLEAR, noise_word());

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        tx_idle_pct = 54;
        rx_idle_pct = 22;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // hold off until the block has drained
      if (i % 200 == 100) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
      end
      pick = $urandom_range(99);
      word = noise_word();
      if (pick < 55) begin
        send(MODE_ADD, word);
      end else if (pick < 72) begin
        seg_word = pack_item('0, '0, 24'($urandom_range(1000)),
                             40'(rand_signed($urandom_range(40, 1))),
                             40'(rand_signed($urandom_range(40, 1))),
                             56'(rand_signed($urandom_range(56, 1))));
        word[191:32] = seg_word[191:32];
        send(MODE_MERGE, word);
      end else if (pick < 78) begin
        send(MODE_CLEAR, word);
      end else if (pick < 82) begin
        send(MODE_SPARE, word);
      end else begin
        send(2'($urandom_range(3)), word);
      end
    end

    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (END_CYCLES) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/core/cov_acc_pkg.sv
rtl/core/cov_acc_ctrl.sv
rtl/core/cov_acc_dp.sv
rtl/core/covariance_accumulator.sv
tb/sv/covariance_checker.sv
tb/sv/testbench.sv
